@@ design/bafc_pkg.sv @@
// Shared types, codes and helpers for the best-fit buddy allocator.
package bafc_pkg;

    localparam int HDR_BYTES = 16;
    localparam int HDR_SHIFT = 4;
    localparam int LOGW      = 5;
    localparam int ENTW      = 7;

    // Block table entry bits
    localparam logic [ENTW-1:0] E_START = 7'h40;
    localparam logic [ENTW-1:0] E_ALLOC = 7'h20;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_bytes;
        logic [15:0] user_address;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] region_address;
        logic [16:0] block_bytes;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_FIN,
        S_SPLIT, S_REL_RD, S_REL_EV, S_OUT
    } t_state;

    typedef struct packed {
        logic clr_init;
        logic clr_wr;
        logic load;
        logic scan_rd;
        logic scan_ev;
        logic res_nofit;
        logic split;
        logic alloc_wr;
        logic rel_rd;
        logic res_bad;
        logic free_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic brk;
        logic found;
        logic can_split;
        logic rel_bad;
        logic rel_ok;
        logic kind;
    } t_sts;

    // Round a requested pool size up to a power of two, floor 32, clamp to max
    function automatic logic [LOGW-1:0] pool_round_log(logic [16:0] w,
                                                        logic [LOGW-1:0] maxlog);
        logic [LOGW-1:0] r;
        r = 5'd24;
        for (int l = 24; l >= 5; l--) begin
            if ((32'(1) << l) >= 32'(w)) begin
                r = LOGW'(l);
            end
        end
        if (r > maxlog) begin
            r = maxlog;
        end
        return r;
    endfunction

endpackage

@@ design/bafc_ctrl.sv @@
// Sequencer for clearing, best-fit scan, split, allocate and release.
module bafc_ctrl
    import bafc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_done
);

    t_state r_state, n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.kind == OP_RELEASE) begin
                    n_state = S_REL_RD;
                end else if (i_sts.scan_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                n_state = i_sts.brk ? S_FIN : S_SCAN_RD;
            end
            S_FIN: begin
                if (i_sts.found) begin
                    n_state = S_SPLIT;
                end else begin
                    o_cmd.res_nofit = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_SPLIT: begin
                if (i_sts.can_split) begin
                    o_cmd.split = 1'b1;
                end else begin
                    o_cmd.alloc_wr = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_REL_RD: begin
                if (i_sts.rel_bad) begin
                    o_cmd.res_bad = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.rel_rd = 1'b1;
                    n_state      = S_REL_EV;
                end
            end
            S_REL_EV: begin
                if (i_sts.rel_ok) o_cmd.free_wr = 1'b1;
                else              o_cmd.res_bad = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // Restart the clearing pass on any pool size write
        if (i_cfg_wr) begin
            o_cmd         = '0;
            o_cmd.clr_init = 1'b1;
            n_state       = S_CLEAR;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

endmodule

@@ design/bafc_dpath.sv @@
// Block table memory, scan index, best-fit tracking and result register.
module bafc_dpath
    import bafc_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int IDXW  = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  t_in             i_item,
    input  logic [LOGW-1:0] i_pool_log,
    output t_sts            o_sts,
    output t_out            o_res
);

    logic [ENTW-1:0] r_mem [DEPTH];
    logic [ENTW-1:0] r_rd;
    logic [IDXW:0]   r_cnt;
    logic            r_kind;
    logic [16:0]     r_need;
    logic [15:0]     r_uaddr;
    logic            r_found;
    logic [IDXW-1:0] r_best;
    logic [LOGW-1:0] r_best_l;
    t_out            r_res;

    logic [15:0]     rel_start;
    logic [31:0]     rel_wide;
    logic [IDXW-1:0] rel_idx;
    logic [LOGW-1:0] e_log;
    logic            fit;
    logic [31:0]     adv_cnt;
    logic [31:0]     upper_w;
    logic [LOGW-1:0] half_l;
    logic [31:0]     addr_w;
    logic [31:0]     bytes_alloc;
    logic [31:0]     bytes_free;
    logic            we;
    logic [IDXW-1:0] waddr;
    logic [ENTW-1:0] wdata;
    logic            re;
    logic [IDXW-1:0] raddr;

    // Decode release address and scan entry
    always_comb begin
        rel_start   = r_uaddr - 16'(HDR_BYTES);
        rel_wide    = 32'(rel_start) >> HDR_SHIFT;
        rel_idx     = rel_wide[IDXW-1:0];
        e_log       = r_rd[LOGW-1:0];
        fit         = ((r_rd & E_ALLOC) == '0) &&
                      ((32'(1) << e_log) >= 32'(r_need)) &&
                      (!r_found || (e_log < r_best_l));
        adv_cnt     = 32'(r_cnt) + (32'(1) << (e_log - LOGW'(HDR_SHIFT)));
        half_l      = r_best_l - 5'd1;
        upper_w     = 32'(r_best) + (32'(1) << (half_l - LOGW'(HDR_SHIFT)));
        addr_w      = (32'(r_best) << HDR_SHIFT) + 32'(HDR_BYTES);
        bytes_alloc = 32'(1) << r_best_l;
        bytes_free  = 32'(1) << e_log;
    end

    // Select memory port addresses and data
    always_comb begin
        we    = 1'b0;
        waddr = r_cnt[IDXW-1:0];
        wdata = '0;
        if (i_cmd.clr_wr) begin
            we    = 1'b1;
            wdata = (r_cnt == '0) ? (E_START | ENTW'(i_pool_log)) : '0;
        end else if (i_cmd.split) begin
            we    = 1'b1;
            waddr = upper_w[IDXW-1:0];
            wdata = E_START | ENTW'(half_l);
        end else if (i_cmd.alloc_wr) begin
            we    = 1'b1;
            waddr = r_best;
            wdata = E_START | E_ALLOC | ENTW'(r_best_l);
        end else if (i_cmd.free_wr) begin
            we    = 1'b1;
            waddr = rel_idx;
            wdata = r_rd & ~E_ALLOC;
        end
        re    = i_cmd.scan_rd | i_cmd.rel_rd;
        raddr = i_cmd.rel_rd ? rel_idx : r_cnt[IDXW-1:0];
    end

    // Write and read the block table
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rd <= r_mem[raddr];
    end

    // Advance the sweep and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_init || i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_cnt <= (r_cnt == (IDXW+1)'(DEPTH - 1)) ? '0 : r_cnt + 1'b1;
        end else if (i_cmd.scan_ev && r_rd[6]) begin
            r_cnt <= adv_cnt[IDXW:0];
        end
    end

    // Capture the item and track the best fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_ev && r_rd[6] && fit) begin
            r_found <= 1'b1;
        end
        if (i_cmd.load) begin
            r_kind  <= i_item.kind;
            r_need  <= {1'b0, i_item.request_bytes} + 17'(HDR_BYTES);
            r_uaddr <= i_item.user_address;
        end
        if (i_cmd.scan_ev && r_rd[6] && fit) begin
            r_best   <= r_cnt[IDXW-1:0];
            r_best_l <= e_log;
        end else if (i_cmd.split) begin
            r_best_l <= half_l;
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_nofit) begin
            r_res <= '{status: ST_NOFIT, region_address: '0, block_bytes: '0};
        end else if (i_cmd.res_bad) begin
            r_res <= '{status: ST_BAD, region_address: '0, block_bytes: '0};
        end else if (i_cmd.alloc_wr) begin
            r_res <= '{status: ST_OK, region_address: addr_w[15:0],
                       block_bytes: bytes_alloc[16:0]};
        end else if (i_cmd.free_wr) begin
            r_res <= '{status: ST_OK, region_address: '0,
                       block_bytes: bytes_free[16:0]};
        end
    end

    assign o_res            = r_res;
    assign o_sts.clr_last   = (r_cnt == (IDXW+1)'(DEPTH - 1));
    assign o_sts.scan_end   = (32'(r_cnt) >= (32'(1) << (i_pool_log - LOGW'(HDR_SHIFT))));
    assign o_sts.brk        = !r_rd[6];
    assign o_sts.found      = r_found;
    assign o_sts.can_split  = (r_best_l > 5'd4) &&
                              ((32'(1) << half_l) >= 32'(r_need));
    assign o_sts.rel_bad    = (rel_start[HDR_SHIFT-1:0] != '0) ||
                              (32'(rel_start) >= (32'(1) << i_pool_log));
    assign o_sts.rel_ok     = r_rd[6] && r_rd[5];
    assign o_sts.kind       = r_kind;

endmodule

@@ design/buddy_allocator_best_fit_core.sv @@
// Top level: configuration port, sequencer and block table datapath.
// Allocate scans the blocks for the best fit, halves it while it can split, then marks it
// allocated (no fit: result after the scan); release checks the address, then the entry.
// Throughput: one item at a time; the next start is taken the cycle after o_done.
// Each result shows for one cycle with o_done; the receiver cannot stall.
// Reset and each pool size write start a clear of all POOL_MAX_BYTES/16 table entries; busy stays high.
module buddy_allocator_best_fit_core
    import bafc_pkg::*;
#(
    parameter int POOL_MAX_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    output logic        o_done,
    output t_out        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MAXLOG = $clog2(POOL_MAX_BYTES);
    localparam int DEPTH  = POOL_MAX_BYTES / HDR_BYTES;
    localparam int IDXW   = $clog2(DEPTH);

    logic [16:0]     r_pool_bytes;
    logic [LOGW-1:0] r_pool_log;
    logic            cfg_wr;
    t_cmd            cmd;
    t_sts            sts;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 1'b0);

    // Hold the pool size register and its rounded log
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_bytes <= 17'h10000;
            r_pool_log   <= pool_round_log(17'h10000, LOGW'(MAXLOG));
        end else if (cfg_wr) begin
            r_pool_bytes <= pwdata[16:0];
            r_pool_log   <= pool_round_log(pwdata[16:0], LOGW'(MAXLOG));
        end
    end

    assign prdata = (paddr == 1'b0) ? {15'd0, r_pool_bytes} : 32'd0;
    assign pready = 1'b1;

    bafc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .start    (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    bafc_dpath #(
        .DEPTH (DEPTH),
        .IDXW  (IDXW)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_pool_log (r_pool_log),
        .o_sts      (sts),
        .o_res      (o_result)
    );

`ifndef SYNTH
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result strobe while idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.block_bytes == '0 && o_result.region_address == '0))
        else $error("error result carries nonzero fields");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_NOFIT ||
                    o_result.status == ST_BAD)) else $error("bad status code");
`endif

endmodule

@@ dv/buddy_allocator_best_fit_core_tb.sv @@
// Self-checking testbench for the best-fit buddy allocator core.
module buddy_allocator_best_fit_core_tb
    import bafc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 4096;
    localparam int CYCLE_LIMIT = 6000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_done;
    t_out        o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buddy_allocator_best_fit_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // Shadow allocator state
    logic [6:0] shadow_table [TABLE_DEPTH];
    int unsigned shadow_pool;

    t_in  pending_cmds [$];
    t_out pending_results [$];
    t_out awaited_results [$];
    t_out cur_result;
    logic [15:0] live_regions [$];
    int   idle_pct = 21;
    bit   took = 1'b0;
    int   errors = 0;
    int   cycles = 0;

    // Reload the shadow pool from a written size
    function automatic void shadow_setup(logic [16:0] want_raw);
        int unsigned want;
        int unsigned r;
        int unsigned lg;
        want = want_raw;
        r = 32;
        lg = 5;
        if (want < 32) want = 32;
        while (r < want) begin
            r = r << 1;
            lg++;
        end
        if (r > 65536) begin
            r = 65536;
            lg = 16;
        end
        shadow_pool = r;
        for (int i = 0; i < TABLE_DEPTH; i++) shadow_table[i] = '0;
        shadow_table[0] = E_START | 7'(lg);
    endfunction

    // Work out the outcome of one command and advance the shadow table
    function automatic t_out buddy_predict(t_in cmd);
        t_out res;
        int unsigned granules, need, i, best, best_size, sz, upper, lg, start_a, idx;
        logic [6:0] e;
        bit found;
        logic [15:0] diff;
        res = '0;
        granules = shadow_pool / HDR_BYTES;
        if (cmd.kind == OP_ALLOC) begin
            need = int'(cmd.request_bytes) + HDR_BYTES;
            i = 0; best = 0; best_size = 0; found = 0;
            while (i < granules) begin
                e = shadow_table[i];
                if ((e & E_START) == 0) break;
                sz = 1 << e[4:0];
                if ((e & E_ALLOC) == 0 && sz >= need && (!found || sz < best_size)) begin
                    found = 1; best = i; best_size = sz;
                end
                i += sz / HDR_BYTES;
            end
            if (!found) begin
                res.status = ST_NOFIT;
                return res;
            end
            while (best_size / 2 >= need && best_size / 2 >= HDR_BYTES) begin
                best_size /= 2;
                upper = best + best_size / HDR_BYTES;
                lg = $clog2(best_size);
                if (upper < TABLE_DEPTH) shadow_table[upper] = E_START | 7'(lg);
            end
            lg = $clog2(best_size);
            shadow_table[best] = E_START | E_ALLOC | 7'(lg);
            res.status = ST_OK;
            res.region_address = 16'(best * HDR_BYTES + HDR_BYTES);
            res.block_bytes = 17'(best_size);
        end else begin
            diff = cmd.user_address - 16'(HDR_BYTES);
            start_a = diff;
            idx = start_a / HDR_BYTES;
            if ((start_a % HDR_BYTES) != 0 || start_a >= shadow_pool) begin
                res.status = ST_BAD;
                return res;
            end
            e = shadow_table[idx];
            if ((e & E_START) == 0 || (e & E_ALLOC) == 0) begin
                res.status = ST_BAD;
                return res;
            end
            shadow_table[idx] = e & ~E_ALLOC;
            res.status = ST_OK;
            res.block_bytes = 17'(1 << e[4:0]);
        end
        return res;
    endfunction

    // Queue one command with its predicted outcome
    task automatic queue_cmd(logic kind, logic [15:0] req, logic [15:0] addr);
        t_in cmd;
        t_out res;
        cmd.kind = kind;
        cmd.request_bytes = req;
        cmd.user_address = addr;
        res = buddy_predict(cmd);
        if (kind == OP_ALLOC && res.status == ST_OK) live_regions.push_back(res.region_address);
        pending_cmds.push_back(cmd);
        pending_results.push_back(res);
    endtask

    task automatic queue_alloc(logic [15:0] req);
        queue_cmd(OP_ALLOC, req, 16'($urandom));
    endtask

    task automatic queue_release(logic [15:0] addr);
        queue_cmd(OP_RELEASE, 16'($urandom), addr);
    endtask

    // Mostly valid alloc/release traffic, with some noise and broken releases
    task automatic queue_random(int n);
        int r, k;
        logic [15:0] a;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 45 || (r >= 55 && r < 85 && live_regions.size() == 0)) begin
                queue_alloc(16'($urandom_range(0, shadow_pool / 8)));
            end else if (r < 55) begin
                queue_alloc(16'($urandom));
            end else if (r < 85) begin
                k = $urandom_range(0, live_regions.size() - 1);
                a = live_regions[k];
                live_regions.delete(k);
                queue_release(a);
                // occasionally release the same region twice
                if ($urandom_range(0, 9) == 0) queue_release(a);
            end else if (r < 92) begin
                queue_release(16'($urandom));
            end else begin
                a = (live_regions.size() != 0) ? live_regions[0] : 16'h0010;
                queue_release(a + 16'($urandom_range(1, 31)));
            end
        end
    endtask

    // Wait until every transfer has been accepted and answered
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || awaited_results.size() != 0 || start || busy);
    endtask

    // Write the pool size register over the configuration port
    task automatic write_pool(logic [16:0] value);
        wait_drained();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_setup(value);
        live_regions.delete();
    endtask

    // Driver: present the next command, hold it until accepted
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            took = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_item <= pending_cmds.pop_front();
                cur_result = pending_results.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
                i_item <= t_in'(33'({$urandom, $urandom}));
            end
        end
    end

    // Monitor: record accepted transfers and check each result
    always @(posedge i_clk) begin
        t_out want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("buddy_allocator_best_fit_core_tb: errors");
            $finish;
        end else begin
            if (i_rst_n && start && !busy && !took) begin
                awaited_results.push_back(cur_result);
                took = 1'b1;
            end
            if (i_rst_n && o_done) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, o_result);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status) begin
                        errors++;
                        $display("%0t: status exp %0d got %0d", $time, want.status,
                                 o_result.status);
                    end
                    if (o_result.region_address !== want.region_address) begin
                        errors++;
                        $display("%0t: region_address exp %h got %h", $time,
                                 want.region_address, o_result.region_address);
                    end
                    if (o_result.block_bytes !== want.block_bytes) begin
                        errors++;
                        $display("%0t: block_bytes exp %0d got %0d", $time,
                                 want.block_bytes, o_result.block_bytes);
                    end
                end
            end
        end
    end

    initial begin
        shadow_setup(17'd65536);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: walk down to the topmost 16-byte block, address wraps to zero
        for (int k = 15; k >= 5; k--) queue_alloc(16'((1 << k) - 16));
        queue_alloc(16'd0);
        queue_alloc(16'd0);
        queue_release(16'h0000);
        queue_release(16'h0000);
        queue_alloc(16'hFFFF);
        queue_release(16'hFFFF);
        queue_release(16'h0018);
        queue_release(16'h0010);
        queue_release(16'h0010);

        // Smallest pool, reached through a size below the floor
        write_pool(17'd0);
        queue_alloc(16'd16);
        queue_alloc(16'd0);
        queue_release(16'h0010);
        queue_alloc(16'd17);
        queue_release(16'h0010);
        queue_random(20);

        // Oversized request clamps to the full pool; sender idles more
        write_pool(17'h1FFFF);
        idle_pct = 76;
        queue_random(25);
        wait_drained();
        queue_random(25);

        // Odd size, no idling
        write_pool(17'd1000);
        idle_pct = 0;
        queue_random(40);

        write_pool(17'd32);
        queue_random(12);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("buddy_allocator_best_fit_core_tb: clean");
        end else begin
            $display("buddy_allocator_best_fit_core_tb: errors");
        end
        $finish;
    end
endmodule
